>>> hdl/lrr_pkg.sv
package lrr_pkg;

  localparam logic [31:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [31:0] LCG_INC = 32'h0026_9EC3;
  localparam logic [31:0] RANGE_LIMIT_RESET = 32'h7FFF_FFFF;

  localparam logic [1:0] KIND_RAW    = 2'd0;
  localparam logic [1:0] KIND_RANGED = 2'd1;
  localparam logic [1:0] KIND_RESEED = 2'd2;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [31:0]        new_seed;
  } in_t;

  typedef struct packed {
    logic [31:0]        raw_value;
    logic signed [31:0] ranged_value;
    logic               bounds_swapped;
    logic               range_error;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_ADD,
    S_DONE
  } state_t;

endpackage

>>> hdl/lcg_ranged_random.sv
// Linear congruential random source (seed * 0x343FD + 0x269EC3, seed resets
// to 0) with a ranged draw. A reseed transaction is absorbed as it is
// accepted and gives no result. A raw draw only updates the seed and returns
// it. A ranged draw runs bound ordering and range check, the seed update, then
// a 32-step restoring remainder loop through one shared 33-bit
// subtract/compare unit, then the final add; that loop sets the rate. A ranged
// draw whose range is at or above range_limit is refused with the seed
// unchanged. The input is stalled while an item is in flight; the result sits
// in an output register, so the next transaction can be taken while it waits to be read.
module lcg_ranged_random (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrr_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrr_pkg::out_t      out_data
);
  import lrr_pkg::*;

  state_t state, state_next;

  logic [31:0]        range_limit;
  logic [31:0]        seed;
  in_t                item;
  logic               is_ranged;
  logic signed [31:0] lo;
  logic [32:0]        divisor;
  logic [31:0]        rem;
  logic [31:0]        dvd;
  logic [4:0]         cnt;
  out_t               res;

  logic               in_accept;
  logic               out_free;
  logic               load_out;

  logic               swap;
  logic signed [31:0] lo_ord;
  logic signed [31:0] hi_ord;
  logic [32:0]        range33;
  logic               refuse;
  logic [31:0]        seed_lcg;
  logic [32:0]        shifted;
  logic [33:0]        diff;
  logic               ge;
  logic [31:0]        rem_next;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign swap     = item.high_bound < item.low_bound;
  assign lo_ord   = swap ? item.high_bound : item.low_bound;
  assign hi_ord   = swap ? item.low_bound : item.high_bound;
  assign range33  = {hi_ord[31], hi_ord} - {lo_ord[31], lo_ord};
  assign refuse   = range33[31:0] >= range_limit;
  assign seed_lcg = seed * LCG_MUL + LCG_INC;

  // shared remainder step
  assign shifted  = {rem, dvd[31]};
  assign diff     = {1'b0, shifted} - {1'b0, divisor};
  assign ge       = !diff[33];
  assign rem_next = ge ? diff[31:0] : shifted[31:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_data.kind)
            KIND_RAW:    state_next = S_MUL;
            KIND_RANGED: state_next = S_PREP;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_PREP:  state_next = refuse ? S_DONE : S_MUL;
      S_MUL:   state_next = is_ranged ? S_DIV : S_DONE;
      S_DIV:   state_next = (cnt == 5'(DIV_STEPS - 1)) ? S_ADD : S_DIV;
      S_ADD:   state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_DONE:  load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      range_limit <= RANGE_LIMIT_RESET;
      seed        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        range_limit <= cfg_data;
      end
      if (state == S_IDLE && in_accept && in_data.kind == KIND_RESEED) begin
        seed <= in_data.new_seed;
      end
      if (state == S_MUL) begin
        seed <= seed_lcg;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          item      <= in_data;
          is_ranged <= in_data.kind == KIND_RANGED;
          res       <= '0;
        end
      end
      S_PREP: begin
        lo                 <= lo_ord;
        divisor            <= range33 + 33'd1;
        res.bounds_swapped <= swap;
        res.range_error    <= refuse;
      end
      S_MUL: begin
        res.raw_value <= seed_lcg;
        dvd           <= seed_lcg;
        rem           <= '0;
        cnt           <= '0;
      end
      S_DIV: begin
        rem <= rem_next;
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
      S_ADD: begin
        res.ranged_value <= lo + $signed(rem);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_data <= res;
    end
  end

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_error |->
      out_data.raw_value == '0 && out_data.ranged_value == '0)
    else $error("refused draw with nonzero value");

  a_refused_seed: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP && refuse |=> $stable(seed))
    else $error("seed moved on refused draw");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> {1'b0, rem} < divisor)
    else $error("remainder not below divisor");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && $past(state) == S_MUL |-> cnt == '0 && rem == '0)
    else $error("divider not cleared at start");

endmodule
